@@ src/bdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants
// Press kind codes, configuration register map and the structs that carry
// configuration and result words between the debounce blocks.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   // press classification codes
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_SHORT = 2'd1,
      KIND_LONG  = 2'd2
   } kind_type;

   // configuration register map (index = byte address / 4)
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic REG_DEBOUNCE   = 1'b0;
   localparam logic REG_HOLD_LIMIT = 1'b1;

   localparam int DEBOUNCE_W = 8;
   localparam int PRESS_W    = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 8'd50;
   localparam logic [PRESS_W-1:0]    HOLD_LIMIT_RESET = 16'd1000;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [PRESS_W-1:0]    hold_limit_ticks;
   } cfg_type;

   typedef struct packed {
      kind_type press_kind;
      logic     stable_pressed;
      logic     press_pending;
   } result_type;

endpackage

@@ src/bdpc_csr.sv @@
// ----------------------------------------------------------------------------
// bdpc_csr: configuration registers
// APB-style register file holding the debounce time and long hold threshold.
// ----------------------------------------------------------------------------
module bdpc_csr
   import bdpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [PRESS_W-1:0]    hold_limit_ff;
   logic                  wr_en;
   logic                  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // write the addressed register on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         hold_limit_ff <= HOLD_LIMIT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_DEBOUNCE:   debounce_ff   <= csr_pwdata[DEBOUNCE_W-1:0];
            REG_HOLD_LIMIT: hold_limit_ff <= csr_pwdata[PRESS_W-1:0];
            default: ;
         endcase
      end
   end

   // read back the addressed register
   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE:   csr_prdata = {{(CSR_DATA_W-DEBOUNCE_W){1'b0}}, debounce_ff};
         REG_HOLD_LIMIT: csr_prdata = {{(CSR_DATA_W-PRESS_W){1'b0}}, hold_limit_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.debounce_ticks   = debounce_ff;
   assign cfg.hold_limit_ticks = hold_limit_ff;

endmodule

@@ src/bdpc_core.sv @@
// ----------------------------------------------------------------------------
// bdpc_core: tick update
// Holds the debounce state and computes one tick's state update and result
// word; the state advances only when the tick is committed.
// ----------------------------------------------------------------------------
module bdpc_core
   import bdpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       tick_en,
   input  logic       pin_level,
   input  logic       take,
   output result_type result
);

   logic                  stable_level_ff, stable_level_in;
   logic [DEBOUNCE_W-1:0] since_change_ff, since_change_in;
   logic [PRESS_W-1:0]    press_ticks_ff,  press_ticks_in;
   kind_type              pending_kind_ff, pending_kind_in;

   logic [DEBOUNCE_W-1:0] since_inc;
   logic [PRESS_W-1:0]    press_inc;
   logic                  change;
   kind_type              kind_upd;

   // count elapsed ticks, saturating
   assign since_inc = (&since_change_ff) ? since_change_ff : since_change_ff + 1'b1;
   assign press_inc = (&press_ticks_ff)  ? press_ticks_ff  : press_ticks_ff  + 1'b1;

   // accept a level change once the lockout has run out
   assign change = (pin_level != stable_level_ff) && (since_inc >= cfg.debounce_ticks);

   always_comb begin
      stable_level_in = stable_level_ff;
      since_change_in = since_inc;
      press_ticks_in  = press_inc;
      kind_upd        = pending_kind_ff;
      if (change) begin
         stable_level_in = pin_level;
         since_change_in = '0;
         if (!pin_level) begin
            press_ticks_in = '0;
            kind_upd       = KIND_NONE;
         end else begin
            kind_upd = (press_inc < cfg.hold_limit_ticks) ? KIND_SHORT : KIND_LONG;
         end
      end
      // take reads and clears the pending kind after the update
      pending_kind_in       = take ? KIND_NONE : kind_upd;
      result.press_kind     = take ? kind_upd : KIND_NONE;
      result.stable_pressed = !stable_level_in;
      result.press_pending  = (pending_kind_in != KIND_NONE);
   end

   // commit the tick
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff <= 1'b1;
         since_change_ff <= '0;
         press_ticks_ff  <= '0;
         pending_kind_ff <= KIND_NONE;
      end else if (tick_en) begin
         stable_level_ff <= stable_level_in;
         since_change_ff <= since_change_in;
         press_ticks_ff  <= press_ticks_in;
         pending_kind_ff <= pending_kind_in;
      end
   end

endmodule

@@ src/button_debounce_press_classifier_top.sv @@
// Words pass the input register, the tick update and the result register to
// the rsp ports, one word per cycle while rsp_ready does not stall; the tick
// state is updated in a single registered step between those two registers.
// Reset (synchronous, active high): level released, counters and pending
// press cleared, debounce 50 ticks, long hold threshold 1000 ticks.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top: debounce and press classifier
// Input register, tick update core, result register and register file.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top
   import bdpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_pin_level,
   input  logic                  req_take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_press_kind,
   output logic                  rsp_stable_pressed,
   output logic                  rsp_press_pending,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff;
   logic       in_pin_ff;
   logic       in_take_ff;
   logic       rsp_valid_ff;
   result_type rsp_word_ff;
   logic       rsp_free;
   logic       advance;

   bdpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // move a word forward when the result register is free or being drained
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && rsp_free;
   assign req_ready = !in_valid_ff || rsp_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_pin_ff  <= req_pin_level;
         in_take_ff <= req_take;
      end
   end

   bdpc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .tick_en   (advance),
      .pin_level (in_pin_ff),
      .take      (in_take_ff),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_press_kind     = rsp_word_ff.press_kind;
   assign rsp_stable_pressed = rsp_word_ff.stable_pressed;
   assign rsp_press_pending  = rsp_word_ff.press_pending;

`ifndef SYNTH
   // a classified press exists only while the button is released
   a_pending_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_pending |-> !rsp_stable_pressed)
      else $error("press pending while button held");

   // a take hands out the kind and leaves nothing pending
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_press_kind != KIND_NONE) |-> !rsp_press_pending)
      else $error("pending press not cleared by take");

   // only the defined kind codes leave the block
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_press_kind == KIND_NONE || rsp_press_kind == KIND_SHORT ||
                     rsp_press_kind == KIND_LONG))
      else $error("undefined press kind");

   // a stalled input word keeps its contents
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_pin_ff) && $stable(in_take_ff))
      else $error("input register lost a stalled word");
`endif

endmodule
